>>> rtl/core/hdpc_pkg.sv
// ----------------------------------------------------------------------------
// hdpc_pkg
// Shared constants, stage context type and arithmetic helpers for the
// disk pair collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hdpc_pkg;

    localparam int MAX_OPENINGS = 4;
    localparam int DIV_STEPS    = 31;

    // stage map of the pipeline
    localparam int ST_ENTRY   = 0;
    localparam int ST_ABS     = 1;
    localparam int ST_SQUARE  = 2;
    localparam int ST_CONTACT = 3;
    localparam int ST_WDIV_LO = 4;
    localparam int ST_WDIV_HI = ST_WDIV_LO + DIV_STEPS - 1;
    localparam int ST_WALL    = ST_WDIV_HI + 1;
    localparam int ST_NDIV_LO = ST_WALL + 1;
    localparam int ST_NDIV_HI = ST_NDIV_LO + DIV_STEPS - 1;
    localparam int ST_NORMAL  = ST_NDIV_HI + 1;
    localparam int ST_PROD    = ST_NORMAL + 1;
    localparam int ST_ROUND   = ST_PROD + 1;
    localparam int ST_PUSH    = ST_ROUND + 1;
    localparam int ST_VEL     = ST_PUSH + 1;
    localparam int NUM_STAGES = ST_VEL + 1;

    // configuration register indexes
    localparam logic [7:0] REG_RADIUS   = 8'd0;
    localparam logic [7:0] REG_WALL_X   = 8'd1;
    localparam logic [7:0] REG_OPEN_H   = 8'd2;
    localparam logic [7:0] REG_OPEN_CNT = 8'd3;
    localparam logic [7:0] REG_CENTER_0 = 8'd4;
    localparam logic [7:0] REG_CENTER_1 = 8'd5;
    localparam logic [7:0] REG_CENTER_2 = 8'd6;
    localparam logic [7:0] REG_CENTER_3 = 8'd7;

    localparam logic [29:0] RADIUS_RESET = 30'd65536;
    localparam logic [31:0] Q30_ONE      = 32'h4000_0000;

    typedef struct packed {
        logic [30:0] rem;
        logic [30:0] low;
        logic [30:0] q;
    } div_st_t;

    typedef struct packed {
        logic [61:0] rad;
        logic [32:0] rem;
        logic [30:0] root;
    } sq_st_t;

    typedef struct packed {
        logic [31:0] ax;
        logic [31:0] ay;
        logic [31:0] avx;
        logic [31:0] avy;
        logic [31:0] bx;
        logic [31:0] by;
        logic [31:0] bvx;
        logic [31:0] bvy;
        logic [32:0] dx;
        logic [32:0] dy;
        logic [32:0] dvx;
        logic [32:0] dvy;
        logic [32:0] wt;
        logic [32:0] wtb;
        logic [32:0] adx;
        logic [32:0] ady;
        logic [32:0] awt;
        logic        near;
        logic        between;
        logic        wneg;
        logic        contact;
        logic        d2z;
        logic        blocked;
        logic        active;
        logic        push;
        logic        relneg;
        logic        exch;
        logic [61:0] sqx;
        logic [61:0] sqy;
        logic [61:0] mdsq;
        logic [61:0] wprod;
        div_st_t     wd;
        logic [30:0] wdiv;
        sq_st_t      sq;
        logic [30:0] corr;
        logic [30:0] ndiv;
        div_st_t     nxd;
        div_st_t     nyd;
        logic [31:0] nx;
        logic [31:0] ny;
        logic [30:0] nxa;
        logic [30:0] nya;
        logic [61:0] pmx;
        logic [61:0] pmy;
        logic [63:0] prx;
        logic [63:0] pry;
        logic [32:0] mx;
        logic [32:0] my;
        logic [35:0] rel;
        logic [64:0] pux;
        logic [64:0] puy;
    } ctx_t;

    typedef struct packed {
        logic [31:0] first_px;
        logic [31:0] first_py;
        logic [31:0] first_vx;
        logic [31:0] first_vy;
        logic [31:0] second_px;
        logic [31:0] second_py;
        logic [31:0] second_vx;
        logic [31:0] second_vy;
        logic        in_contact;
        logic        wall_blocked;
        logic        velocities_exchanged;
    } out_t;

    // one restoring division step, one quotient bit
    function automatic div_st_t div_step(input div_st_t s, input logic [30:0] dvs);
        logic [31:0] t;
        logic        ge;
        div_st_t     r;
        t     = {s.rem, s.low[30]};
        ge    = (t >= {1'b0, dvs});
        r.rem = ge ? 31'(t - {1'b0, dvs}) : t[30:0];
        r.low = {s.low[29:0], 1'b0};
        r.q   = {s.q[29:0], ge};
        return r;
    endfunction

    // one square root step, two radicand bits per step
    function automatic sq_st_t sq_step(input sq_st_t s);
        logic [34:0] r;
        logic [34:0] trial;
        sq_st_t      o;
        r     = {s.rem, s.rad[61:60]};
        trial = {2'b00, s.root, 2'b01};
        if (r >= trial) begin
            o.rem  = 33'(r - trial);
            o.root = {s.root[29:0], 1'b1};
        end else begin
            o.rem  = r[32:0];
            o.root = {s.root[29:0], 1'b0};
        end
        o.rad = {s.rad[59:0], 2'b00};
        return o;
    endfunction

    // magnitude product scaled by 2^-30, rounded half up
    function automatic logic [35:0] round_q30(input logic [65:0] p);
        logic [66:0] t;
        t = {1'b0, p} + 67'h2000_0000;
        return t[65:30];
    endfunction

    function automatic logic [31:0] sat_cw(input logic [39:0] v);
        if ($signed(v) > $signed(40'h00_7fff_ffff)) begin
            return 32'h7fff_ffff;
        end else if ($signed(v) < $signed(40'hff_8000_0000)) begin
            return 32'h8000_0000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/hard_disk_pair_collision_top.sv
// ----------------------------------------------------------------------------
// hard_disk_pair_collision_top
// Equal-mass elastic collision of a disk pair in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
// usage
//   s_* carries one disk pair per transaction (valid/ready), m_* returns the
//   updated pair plus the contact, wall and exchange flags, one result per
//   input transaction, in order.
//   cfg_* writes one register per transaction (index, data); cfg_ready is
//   always high. write only while no transaction is in flight.
// depth and throughput
//   a pair accepted at an edge enters the first of 72 stage registers at
//   that edge, passes through the rest in order, then loads the output
//   register. one pair per cycle is sustained while the skid entry is empty.
//   the depth comes from the floor square root and the two divisions
//   (wall crossing height, then the unit normal), each resolving one result
//   bit per stage.
// reset
//   aresetn (synchronous, active low) empties the pipeline and restores the
//   register defaults: radius 1.0, no wall openings.
// stalls
//   while m_ready is low the pipe keeps moving until a one-entry skid buffer
//   behind the output register fills; then s_ready drops and the whole pipe
//   holds. nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module hard_disk_pair_collision_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // input pair
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_first_px,
    input  wire logic [31:0] s_first_py,
    input  wire logic [31:0] s_first_vx,
    input  wire logic [31:0] s_first_vy,
    input  wire logic [31:0] s_second_px,
    input  wire logic [31:0] s_second_py,
    input  wire logic [31:0] s_second_vx,
    input  wire logic [31:0] s_second_vy,
    // result pair
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_new_first_px,
    output logic [31:0]      m_new_first_py,
    output logic [31:0]      m_new_first_vx,
    output logic [31:0]      m_new_first_vy,
    output logic [31:0]      m_new_second_px,
    output logic [31:0]      m_new_second_py,
    output logic [31:0]      m_new_second_vx,
    output logic [31:0]      m_new_second_vy,
    output logic             m_in_contact,
    output logic             m_wall_blocked,
    output logic             m_velocities_exchanged
);
    import hdpc_pkg::*;

    // configuration registers
    logic [29:0] radius_reg;
    logic [30:0] wall_x_reg;
    logic [30:0] open_h_reg;
    logic [2:0]  open_cnt_reg;
    logic [30:0] open_c_reg [MAX_OPENINGS];
    logic [30:0] md;

    // pipeline
    ctx_t                  ctx_reg  [NUM_STAGES];
    ctx_t                  ctx_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] vld_reg;
    logic                  adv;
    logic                  push_out;

    // output register and skid entry
    out_t fin;
    out_t m_data_reg;
    out_t skid_data_reg;
    logic m_vld_reg;
    logic skid_vld_reg;
    logic out_free;

    assign cfg_ready = 1'b1;
    assign md        = {radius_reg, 1'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg   <= RADIUS_RESET;
            wall_x_reg   <= '0;
            open_h_reg   <= '0;
            open_cnt_reg <= '0;
            for (int i = 0; i < MAX_OPENINGS; i++) begin
                open_c_reg[i] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_RADIUS:   radius_reg    <= cfg_data[29:0];
                REG_WALL_X:   wall_x_reg    <= cfg_data[30:0];
                REG_OPEN_H:   open_h_reg    <= cfg_data[30:0];
                REG_OPEN_CNT: open_cnt_reg  <= cfg_data[2:0];
                REG_CENTER_0: open_c_reg[0] <= cfg_data[30:0];
                REG_CENTER_1: open_c_reg[1] <= cfg_data[30:0];
                REG_CENTER_2: open_c_reg[2] <= cfg_data[30:0];
                REG_CENTER_3: open_c_reg[3] <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // whole pipe moves together, held only when the skid entry is occupied
    assign adv      = !skid_vld_reg;
    assign s_ready  = adv;
    assign push_out = vld_reg[NUM_STAGES-1] && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NUM_STAGES-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                ctx_reg[k] <= ctx_next[k];
            end
        end
    end

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        if (k == ST_ENTRY) begin : g_entry
            // differences straight off the ports
            always_comb begin
                ctx_next[k]     = '0;
                ctx_next[k].ax  = s_first_px;
                ctx_next[k].ay  = s_first_py;
                ctx_next[k].avx = s_first_vx;
                ctx_next[k].avy = s_first_vy;
                ctx_next[k].bx  = s_second_px;
                ctx_next[k].by  = s_second_py;
                ctx_next[k].bvx = s_second_vx;
                ctx_next[k].bvy = s_second_vy;
                ctx_next[k].dx  = {s_second_px[31], s_second_px} - {s_first_px[31], s_first_px};
                ctx_next[k].dy  = {s_second_py[31], s_second_py} - {s_first_py[31], s_first_py};
                ctx_next[k].dvx = {s_second_vx[31], s_second_vx} - {s_first_vx[31], s_first_vx};
                ctx_next[k].dvy = {s_second_vy[31], s_second_vy} - {s_first_vy[31], s_first_vy};
                ctx_next[k].wt  = {2'b00, wall_x_reg} - {s_first_px[31], s_first_px};
                ctx_next[k].wtb = {2'b00, wall_x_reg} - {s_second_px[31], s_second_px};
            end
        end else if (k == ST_ABS) begin : g_abs
            always_comb begin
                ctx_next[k]         = ctx_reg[k-1];
                ctx_next[k].adx     = ctx_reg[k-1].dx[32] ? 33'd0 - ctx_reg[k-1].dx
                                                          : ctx_reg[k-1].dx;
                ctx_next[k].ady     = ctx_reg[k-1].dy[32] ? 33'd0 - ctx_reg[k-1].dy
                                                          : ctx_reg[k-1].dy;
                ctx_next[k].awt     = ctx_reg[k-1].wt[32] ? 33'd0 - ctx_reg[k-1].wt
                                                          : ctx_reg[k-1].wt;
                ctx_next[k].near    = (ctx_next[k].adx < {2'b00, md})
                                   && (ctx_next[k].ady < {2'b00, md});
                // wall strictly between the centres: w - ax and w - bx of opposite sign
                ctx_next[k].between =
                    (!ctx_reg[k-1].wt[32] && ctx_reg[k-1].wt != '0 && ctx_reg[k-1].wtb[32])
                 || (ctx_reg[k-1].wt[32] && !ctx_reg[k-1].wtb[32] && ctx_reg[k-1].wtb != '0);
                // (w - ax) and dx share a sign when between, so the offset follows dy
                ctx_next[k].wneg    = ctx_reg[k-1].dy[32];
            end
        end else if (k == ST_SQUARE) begin : g_square
            always_comb begin
                ctx_next[k]       = ctx_reg[k-1];
                ctx_next[k].sqx   = {31'd0, ctx_reg[k-1].adx[30:0]}
                                  * {31'd0, ctx_reg[k-1].adx[30:0]};
                ctx_next[k].sqy   = {31'd0, ctx_reg[k-1].ady[30:0]}
                                  * {31'd0, ctx_reg[k-1].ady[30:0]};
                ctx_next[k].mdsq  = {31'd0, md} * {31'd0, md};
                ctx_next[k].wprod = {31'd0, ctx_reg[k-1].awt[30:0]}
                                  * {31'd0, ctx_reg[k-1].ady[30:0]};
            end
        end else if (k == ST_CONTACT) begin : g_contact
            always_comb begin
                logic [62:0] d2;
                d2                  = {1'b0, ctx_reg[k-1].sqx} + {1'b0, ctx_reg[k-1].sqy};
                ctx_next[k]         = ctx_reg[k-1];
                ctx_next[k].contact = ctx_reg[k-1].near && (d2 < {1'b0, ctx_reg[k-1].mdsq});
                ctx_next[k].d2z     = (d2 == '0);
                ctx_next[k].sq.rad  = d2[61:0];
                ctx_next[k].sq.rem  = '0;
                ctx_next[k].sq.root = '0;
                ctx_next[k].wd.rem  = ctx_reg[k-1].wprod[61:31];
                ctx_next[k].wd.low  = ctx_reg[k-1].wprod[30:0];
                ctx_next[k].wd.q    = '0;
                ctx_next[k].wdiv    = ctx_reg[k-1].adx[30:0];
            end
        end else if (k >= ST_WDIV_LO && k <= ST_WDIV_HI) begin : g_wdiv
            // crossing-height division and square root, one bit each per stage
            always_comb begin
                ctx_next[k]    = ctx_reg[k-1];
                ctx_next[k].wd = div_step(ctx_reg[k-1].wd, ctx_reg[k-1].wdiv);
                ctx_next[k].sq = sq_step(ctx_reg[k-1].sq);
            end
        end else if (k == ST_WALL) begin : g_wall
            always_comb begin
                logic [33:0] qext;
                logic [33:0] yc;
                logic [34:0] y2;
                logic [34:0] lo;
                logic [34:0] hi;
                logic [2:0]  ncnt;
                logic        inopen;
                logic [30:0] cdist;
                logic [31:0] ov;
                qext   = {3'b000, ctx_reg[k-1].wd.q};
                yc     = {{2{ctx_reg[k-1].ay[31]}}, ctx_reg[k-1].ay}
                       + (ctx_reg[k-1].wneg ? 34'd0 - qext : qext);
                y2     = {yc, 1'b0};
                ncnt   = (open_cnt_reg > 3'(MAX_OPENINGS)) ? 3'(MAX_OPENINGS) : open_cnt_reg;
                inopen = 1'b0;
                for (int i = 0; i < MAX_OPENINGS; i++) begin
                    lo = {3'b000, open_c_reg[i], 1'b0} - {4'b0000, open_h_reg} + {4'b0000, md};
                    hi = {3'b000, open_c_reg[i], 1'b0} + {4'b0000, open_h_reg} - {4'b0000, md};
                    if ((3'(i) < ncnt) && ($signed(y2) >= $signed(lo))
                            && ($signed(y2) <= $signed(hi))) begin
                        inopen = 1'b1;
                    end
                end
                // coincident centres take the full contact distance, so no push
                cdist = ctx_reg[k-1].d2z ? md : ctx_reg[k-1].sq.root;
                ov    = {1'b0, md} - {1'b0, cdist};

                ctx_next[k]         = ctx_reg[k-1];
                ctx_next[k].blocked = ctx_reg[k-1].contact && ctx_reg[k-1].between && !inopen;
                ctx_next[k].active  = ctx_reg[k-1].contact
                                   && !(ctx_reg[k-1].between && !inopen);
                ctx_next[k].push    = !ov[31] && (ov != '0);
                ctx_next[k].corr    = ov[31:1] + 31'd1;
                ctx_next[k].ndiv    = cdist;
                ctx_next[k].nxd.rem = {1'b0, ctx_reg[k-1].adx[30:1]};
                ctx_next[k].nxd.low = {ctx_reg[k-1].adx[0], 30'd0};
                ctx_next[k].nxd.q   = '0;
                ctx_next[k].nyd.rem = {1'b0, ctx_reg[k-1].ady[30:1]};
                ctx_next[k].nyd.low = {ctx_reg[k-1].ady[0], 30'd0};
                ctx_next[k].nyd.q   = '0;
            end
        end else if (k >= ST_NDIV_LO && k <= ST_NDIV_HI) begin : g_ndiv
            always_comb begin
                ctx_next[k]     = ctx_reg[k-1];
                ctx_next[k].nxd = div_step(ctx_reg[k-1].nxd, ctx_reg[k-1].ndiv);
                ctx_next[k].nyd = div_step(ctx_reg[k-1].nyd, ctx_reg[k-1].ndiv);
            end
        end else if (k == ST_NORMAL) begin : g_normal
            always_comb begin
                ctx_next[k] = ctx_reg[k-1];
                if (ctx_reg[k-1].d2z) begin
                    ctx_next[k].nx = Q30_ONE;
                    ctx_next[k].ny = '0;
                end else begin
                    ctx_next[k].nx = ctx_reg[k-1].dx[32] ? 32'd0 - {1'b0, ctx_reg[k-1].nxd.q}
                                                         : {1'b0, ctx_reg[k-1].nxd.q};
                    ctx_next[k].ny = ctx_reg[k-1].dy[32] ? 32'd0 - {1'b0, ctx_reg[k-1].nyd.q}
                                                         : {1'b0, ctx_reg[k-1].nyd.q};
                end
            end
        end else if (k == ST_PROD) begin : g_prod
            always_comb begin
                logic [31:0] anx;
                logic [31:0] any_n;
                logic [32:0] advx;
                logic [32:0] advy;
                anx   = ctx_reg[k-1].nx[31] ? 32'd0 - ctx_reg[k-1].nx : ctx_reg[k-1].nx;
                any_n = ctx_reg[k-1].ny[31] ? 32'd0 - ctx_reg[k-1].ny : ctx_reg[k-1].ny;
                advx  = ctx_reg[k-1].dvx[32] ? 33'd0 - ctx_reg[k-1].dvx : ctx_reg[k-1].dvx;
                advy  = ctx_reg[k-1].dvy[32] ? 33'd0 - ctx_reg[k-1].dvy : ctx_reg[k-1].dvy;
                ctx_next[k]     = ctx_reg[k-1];
                ctx_next[k].nxa = anx[30:0];
                ctx_next[k].nya = any_n[30:0];
                ctx_next[k].pmx = {31'd0, ctx_reg[k-1].corr} * {31'd0, anx[30:0]};
                ctx_next[k].pmy = {31'd0, ctx_reg[k-1].corr} * {31'd0, any_n[30:0]};
                ctx_next[k].prx = {31'd0, advx} * {33'd0, anx[30:0]};
                ctx_next[k].pry = {31'd0, advy} * {33'd0, any_n[30:0]};
            end
        end else if (k == ST_ROUND) begin : g_round
            always_comb begin
                logic [35:0] mmx;
                logic [35:0] mmy;
                logic [35:0] rmx;
                logic [35:0] rmy;
                logic [35:0] rx;
                logic [35:0] ry;
                mmx = round_q30({4'd0, ctx_reg[k-1].pmx});
                mmy = round_q30({4'd0, ctx_reg[k-1].pmy});
                rmx = round_q30({2'd0, ctx_reg[k-1].prx});
                rmy = round_q30({2'd0, ctx_reg[k-1].pry});
                rx  = (ctx_reg[k-1].dvx[32] ^ ctx_reg[k-1].nx[31]) ? 36'd0 - rmx : rmx;
                ry  = (ctx_reg[k-1].dvy[32] ^ ctx_reg[k-1].ny[31]) ? 36'd0 - rmy : rmy;
                ctx_next[k]     = ctx_reg[k-1];
                ctx_next[k].mx  = ctx_reg[k-1].nx[31] ? 33'd0 - mmx[32:0] : mmx[32:0];
                ctx_next[k].my  = ctx_reg[k-1].ny[31] ? 33'd0 - mmy[32:0] : mmy[32:0];
                ctx_next[k].rel = rx + ry;
            end
        end else if (k == ST_PUSH) begin : g_push
            always_comb begin
                logic [35:0] arel;
                arel = ctx_reg[k-1].rel[35] ? 36'd0 - ctx_reg[k-1].rel : ctx_reg[k-1].rel;
                ctx_next[k]        = ctx_reg[k-1];
                ctx_next[k].relneg = ctx_reg[k-1].rel[35];
                ctx_next[k].pux    = {31'd0, arel[33:0]} * {34'd0, ctx_reg[k-1].nxa};
                ctx_next[k].puy    = {31'd0, arel[33:0]} * {34'd0, ctx_reg[k-1].nya};
                // separate the pair along the normal, a backwards and b forwards
                if (ctx_reg[k-1].active && ctx_reg[k-1].push) begin
                    ctx_next[k].ax = sat_cw({{8{ctx_reg[k-1].ax[31]}}, ctx_reg[k-1].ax}
                                          - {{7{ctx_reg[k-1].mx[32]}}, ctx_reg[k-1].mx});
                    ctx_next[k].ay = sat_cw({{8{ctx_reg[k-1].ay[31]}}, ctx_reg[k-1].ay}
                                          - {{7{ctx_reg[k-1].my[32]}}, ctx_reg[k-1].my});
                    ctx_next[k].bx = sat_cw({{8{ctx_reg[k-1].bx[31]}}, ctx_reg[k-1].bx}
                                          + {{7{ctx_reg[k-1].mx[32]}}, ctx_reg[k-1].mx});
                    ctx_next[k].by = sat_cw({{8{ctx_reg[k-1].by[31]}}, ctx_reg[k-1].by}
                                          + {{7{ctx_reg[k-1].my[32]}}, ctx_reg[k-1].my});
                end
            end
        end else begin : g_vel
            always_comb begin
                logic [35:0] umx;
                logic [35:0] umy;
                logic [36:0] ux;
                logic [36:0] uy;
                umx = round_q30({1'b0, ctx_reg[k-1].pux});
                umy = round_q30({1'b0, ctx_reg[k-1].puy});
                ux  = (ctx_reg[k-1].relneg ^ ctx_reg[k-1].nx[31]) ? 37'd0 - {1'b0, umx}
                                                                  : {1'b0, umx};
                uy  = (ctx_reg[k-1].relneg ^ ctx_reg[k-1].ny[31]) ? 37'd0 - {1'b0, umy}
                                                                  : {1'b0, umy};
                ctx_next[k]      = ctx_reg[k-1];
                ctx_next[k].exch = ctx_reg[k-1].active && ctx_reg[k-1].relneg;
                // approaching pair swaps its normal velocity components
                if (ctx_next[k].exch) begin
                    ctx_next[k].avx = sat_cw({{8{ctx_reg[k-1].avx[31]}}, ctx_reg[k-1].avx}
                                           + {{3{ux[36]}}, ux});
                    ctx_next[k].avy = sat_cw({{8{ctx_reg[k-1].avy[31]}}, ctx_reg[k-1].avy}
                                           + {{3{uy[36]}}, uy});
                    ctx_next[k].bvx = sat_cw({{8{ctx_reg[k-1].bvx[31]}}, ctx_reg[k-1].bvx}
                                           - {{3{ux[36]}}, ux});
                    ctx_next[k].bvy = sat_cw({{8{ctx_reg[k-1].bvy[31]}}, ctx_reg[k-1].bvy}
                                           - {{3{uy[36]}}, uy});
                end
            end
        end
    end

    // final stage packed for the output side
    always_comb begin
        fin.first_px             = ctx_reg[NUM_STAGES-1].ax;
        fin.first_py             = ctx_reg[NUM_STAGES-1].ay;
        fin.first_vx             = ctx_reg[NUM_STAGES-1].avx;
        fin.first_vy             = ctx_reg[NUM_STAGES-1].avy;
        fin.second_px            = ctx_reg[NUM_STAGES-1].bx;
        fin.second_py            = ctx_reg[NUM_STAGES-1].by;
        fin.second_vx            = ctx_reg[NUM_STAGES-1].bvx;
        fin.second_vy            = ctx_reg[NUM_STAGES-1].bvy;
        fin.in_contact           = ctx_reg[NUM_STAGES-1].contact;
        fin.wall_blocked         = ctx_reg[NUM_STAGES-1].blocked;
        fin.velocities_exchanged = ctx_reg[NUM_STAGES-1].exch;
    end

    // output register with one skid entry behind it
    assign out_free = !m_vld_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_vld_reg) begin
                m_vld_reg    <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                m_vld_reg <= push_out;
            end
        end else if (push_out) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_data_reg <= skid_vld_reg ? skid_data_reg : fin;
        end
        if (!out_free && push_out) begin
            skid_data_reg <= fin;
        end
    end

    assign m_valid                = m_vld_reg;
    assign m_new_first_px         = m_data_reg.first_px;
    assign m_new_first_py         = m_data_reg.first_py;
    assign m_new_first_vx         = m_data_reg.first_vx;
    assign m_new_first_vy         = m_data_reg.first_vy;
    assign m_new_second_px        = m_data_reg.second_px;
    assign m_new_second_py        = m_data_reg.second_py;
    assign m_new_second_vx        = m_data_reg.second_vx;
    assign m_new_second_vy        = m_data_reg.second_vy;
    assign m_in_contact           = m_data_reg.in_contact;
    assign m_wall_blocked         = m_data_reg.wall_blocked;
    assign m_velocities_exchanged = m_data_reg.velocities_exchanged;

endmodule

`default_nettype wire

>>> rtl/core/hdpc_checker.sv
// ----------------------------------------------------------------------------
// hdpc_checker
// Port-level checks on the result channel of the collision pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module hdpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_new_first_px,
    input wire logic        m_in_contact,
    input wire logic        m_wall_blocked,
    input wire logic        m_velocities_exchanged
);

    // a held result transaction stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_new_first_px))
        else $error("result changed while stalled");

    // flags only without contact are all clear
    a_flags_contact: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_in_contact |-> !m_wall_blocked && !m_velocities_exchanged)
        else $error("flag set without contact");

    // a blocked pair never exchanges velocities
    a_blocked_no_exch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_wall_blocked |-> !m_velocities_exchanged)
        else $error("exchange on a wall blocked pair");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind hard_disk_pair_collision_top hdpc_checker u_hdpc_checker (.*);

`default_nettype wire
